// ===== sv/fqas_pkg.sv =====
// shared constants, codes and types for the affine-scale fifo queue
package fqas_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	// action codes carried on the input tuser
	localparam logic [1:0] ACT_PUSH  = 2'd0;
	localparam logic [1:0] ACT_POP   = 2'd1;
	localparam logic [1:0] ACT_SCALE = 2'd2;

	// status codes carried on the output tuser
	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	// one write into the ring store
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] data;
	} wr_t;

	// ring index advance with wrap at the store depth
	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] nxt;
		if (idx == IDX_W'(DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = idx + IDX_W'(1);
		end
		return nxt;
	endfunction

endpackage

// ===== sv/fqas_ram.sv =====
// generic simple dual-port ram with registered read
module fqas_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/fqas_mac.sv =====
// multiply-add stage for the scale walk: registered product, then add and write back
module fqas_mac (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [fqas_pkg::WORD_W-1:0]  in_word,
	input  logic [fqas_pkg::IDX_W-1:0]   in_idx,
	input  logic [fqas_pkg::WORD_W-1:0]  multiplier,
	input  logic [fqas_pkg::WORD_W-1:0]  addend,
	output fqas_pkg::wr_t                wr
);

	logic [fqas_pkg::WORD_W-1:0]   prod_lo;
	logic                          valid_s1;
	logic [fqas_pkg::IDX_W-1:0]    idx_s1;
	logic [fqas_pkg::WORD_W-1:0]   prod_s1;

	// low word of the product only, wraps modulo 2^32
	assign prod_lo = in_word * multiplier;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= in_idx;
		prod_s1 <= prod_lo;
	end

	// low word only, wraps modulo 2^32
	assign wr.en   = valid_s1;
	assign wr.idx  = idx_s1;
	assign wr.data = prod_s1 + addend;

endmodule

// ===== sv/fifo_queue_with_affine_scale.sv =====
// top level of the ring-store fifo queue with in-place affine scale
//
//  channel   dir  tdata                                   tuser
//  s_*       in   [31:0] push_word [63:32] multiplier     [1:0] action
//                 [95:64] addend
//  m_*       out  [31:0] pop_word                         [1:0] status [2] is_empty
//
// push, refused pop, empty scale and unused codes: result registered at the accept edge,
// next item can be taken the following cycle, provided that result is taken
// pop: the head word comes back from the ring store's registered read in ST_POP and is the result
// scale of n entries: one entry a cycle through read, multiply and add
// stages that share the store's single read and single write port
// reset clears indexes, count and output valid; the store itself is not cleared
// a waiting result holds the input off only until it is taken; one item is in work at a time
module fifo_queue_with_affine_scale (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // push_word, multiplier, addend
	input  logic [1:0]   s_tuser,   // action
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,   // pop_word
	output logic [2:0]   m_tuser    // status, is_empty
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_SCALE
	} state_t;

	state_t                        state_q;
	logic [fqas_pkg::IDX_W-1:0]    head_q;
	logic [fqas_pkg::IDX_W-1:0]    tail_q;
	logic [fqas_pkg::CNT_W-1:0]    count_q;

	// output register
	logic                          m_valid_q;
	logic [1:0]                    m_status_q;
	logic [fqas_pkg::WORD_W-1:0]   m_word_q;
	logic                          m_empty_q;

	// scale walk
	logic [fqas_pkg::WORD_W-1:0]   mul_q;
	logic [fqas_pkg::WORD_W-1:0]   add_q;
	logic [fqas_pkg::CNT_W-1:0]    rd_left_q;
	logic [fqas_pkg::IDX_W-1:0]    rd_idx_q;
	logic                          rd_v_s1;
	logic [fqas_pkg::IDX_W-1:0]    rd_idx_s1;

	// input fields
	logic [1:0]                    action;
	logic [fqas_pkg::WORD_W-1:0]   push_word;
	logic [fqas_pkg::WORD_W-1:0]   multiplier;
	logic [fqas_pkg::WORD_W-1:0]   addend;

	logic                          accept;
	logic                          q_full;
	logic                          q_zero;

	// ring store port signals
	logic                          ram_we;
	logic [fqas_pkg::IDX_W-1:0]    ram_waddr;
	logic [fqas_pkg::WORD_W-1:0]   ram_wdata;
	logic                          ram_re;
	logic [fqas_pkg::IDX_W-1:0]    ram_raddr;
	logic [fqas_pkg::WORD_W-1:0]   ram_rdata;
	fqas_pkg::wr_t                 mac_wr;

	assign action     = s_tuser;
	assign push_word  = s_tdata[31:0];
	assign multiplier = s_tdata[63:32];
	assign addend     = s_tdata[95:64];

	assign q_full = (count_q == fqas_pkg::CNT_W'(fqas_pkg::DEPTH));
	assign q_zero = (count_q == '0);

	// take a new item only when idle and the output slot is free or being freed
	assign s_tready = (state_q == ST_IDLE) && (!m_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_word_q;
	assign m_tuser  = {m_empty_q, m_status_q};

	// write port: a push at accept, otherwise the scale write-back; never both
	always_comb begin
		if (accept && (action == fqas_pkg::ACT_PUSH) && !q_full) begin
			ram_we    = 1'b1;
			ram_waddr = tail_q;
			ram_wdata = push_word;
		end else begin
			ram_we    = mac_wr.en;
			ram_waddr = mac_wr.idx;
			ram_wdata = mac_wr.data;
		end
	end

	// read port: head word on a pop, walk pointer during a scale
	always_comb begin
		if (state_q == ST_SCALE) begin
			ram_re    = (rd_left_q != '0);
			ram_raddr = rd_idx_q;
		end else begin
			ram_re    = accept && (action == fqas_pkg::ACT_POP) && !q_zero;
			ram_raddr = head_q;
		end
	end

	fqas_ram #(
		.WIDTH (fqas_pkg::WORD_W),
		.DEPTH (fqas_pkg::DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// read data arrives in the cycle after the walk issues its address
	fqas_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (rd_v_s1),
		.in_word    (ram_rdata),
		.in_idx     (rd_idx_s1),
		.multiplier (mul_q),
		.addend     (add_q),
		.wr         (mac_wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			m_valid_q  <= 1'b0;
			m_status_q <= fqas_pkg::STATUS_DONE;
			m_word_q   <= '0;
			m_empty_q  <= 1'b1;
			mul_q      <= '0;
			add_q      <= '0;
			rd_left_q  <= '0;
			rd_idx_q   <= '0;
			rd_v_s1    <= 1'b0;
			rd_idx_s1  <= '0;
		end else begin
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			rd_v_s1 <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (action)
							fqas_pkg::ACT_PUSH: begin
								m_valid_q <= 1'b1;
								m_word_q  <= '0;
								if (q_full) begin
									m_status_q <= fqas_pkg::STATUS_FULL;
									m_empty_q  <= q_zero;
								end else begin
									m_status_q <= fqas_pkg::STATUS_DONE;
									m_empty_q  <= 1'b0;
									tail_q     <= fqas_pkg::next_idx(tail_q);
									count_q    <= count_q + fqas_pkg::CNT_W'(1);
								end
							end
							fqas_pkg::ACT_POP: begin
								if (q_zero) begin
									m_valid_q  <= 1'b1;
									m_word_q   <= '0;
									m_status_q <= fqas_pkg::STATUS_EMPTY;
									m_empty_q  <= 1'b1;
								end else begin
									// result follows when the head word comes back
									head_q  <= fqas_pkg::next_idx(head_q);
									count_q <= count_q - fqas_pkg::CNT_W'(1);
									state_q <= ST_POP;
								end
							end
							fqas_pkg::ACT_SCALE: begin
								// result is known now; the walk runs with input held off
								m_valid_q  <= 1'b1;
								m_word_q   <= '0;
								m_status_q <= fqas_pkg::STATUS_DONE;
								m_empty_q  <= q_zero;
								mul_q      <= multiplier;
								add_q      <= addend;
								if (!q_zero) begin
									rd_left_q <= count_q;
									rd_idx_q  <= head_q;
									state_q   <= ST_SCALE;
								end
							end
							default: begin
								m_valid_q  <= 1'b1;
								m_word_q   <= '0;
								m_status_q <= fqas_pkg::STATUS_DONE;
								m_empty_q  <= q_zero;
							end
						endcase
					end
				end
				ST_POP: begin
					m_valid_q  <= 1'b1;
					m_word_q   <= ram_rdata;
					m_status_q <= fqas_pkg::STATUS_DONE;
					m_empty_q  <= q_zero;
					state_q    <= ST_IDLE;
				end
				ST_SCALE: begin
					if (rd_left_q != '0) begin
						rd_left_q <= rd_left_q - fqas_pkg::CNT_W'(1);
						rd_idx_q  <= fqas_pkg::next_idx(rd_idx_q);
						rd_v_s1   <= 1'b1;
						rd_idx_s1 <= rd_idx_q;
					end else if (!rd_v_s1) begin
						// last write-back lands at this edge
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/fqas_checker.sv =====
// port-level checker for the affine-scale fifo queue, bound to the top level
module fqas_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [31:0]  m_tdata,
	input logic [2:0]   m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// only defined status codes appear
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[1:0] == fqas_pkg::STATUS_DONE)
			|| (m_tuser[1:0] == fqas_pkg::STATUS_FULL)
			|| (m_tuser[1:0] == fqas_pkg::STATUS_EMPTY))
		else $error("undefined status code");

	// a refused item carries no word
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] != fqas_pkg::STATUS_DONE) |-> (m_tdata == '0))
		else $error("refused item carries a word");

	// full and empty refusals agree with the empty flag
	a_refusal_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tuser[1:0] != fqas_pkg::STATUS_FULL) || !m_tuser[2])
			&& ((m_tuser[1:0] != fqas_pkg::STATUS_EMPTY) || m_tuser[2]))
		else $error("refusal status disagrees with empty flag");

endmodule

bind fifo_queue_with_affine_scale fqas_checker u_fqas_checker (.*);

// ===== dv/fifo_queue_with_affine_scale_tb.sv =====
// self-checking testbench for the ring-store fifo queue with in-place affine scale
module fifo_queue_with_affine_scale_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// code the block must ignore, never produced by a well-formed sender
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 1950;
	localparam int DRAIN_CYCLES = fqas_pkg::DEPTH + 24;

	// one item for the input channel, or a marker that holds the sender off
	typedef struct {
		logic [1:0]                  action;
		logic [fqas_pkg::WORD_W-1:0] push_word;
		logic [fqas_pkg::WORD_W-1:0] multiplier;
		logic [fqas_pkg::WORD_W-1:0] addend;
		bit                          hold;
	} queue_op_t;

	// one result item as seen on the output channel
	typedef struct {
		logic [1:0]                  status;
		logic [fqas_pkg::WORD_W-1:0] pop_word;
		logic                        is_empty;
	} queue_outcome_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [95:0]       s_tdata = '0;   // push_word, multiplier, addend
	logic [1:0]        s_tuser = '0;   // action
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [31:0]       m_tdata;        // pop_word
	logic [2:0]        m_tuser;        // status, is_empty

	// shadow copy of the queue, advanced once per accepted item
	logic [fqas_pkg::WORD_W-1:0] shadow_ring [fqas_pkg::DEPTH];
	logic [fqas_pkg::IDX_W-1:0]  shadow_head = '0;
	logic [fqas_pkg::IDX_W-1:0]  shadow_tail = '0;
	int                          shadow_count = 0;

	queue_op_t         op_backlog [$];
	queue_outcome_t    awaited_outcomes [$];
	queue_op_t         live_op;

	int cycle_count = 0;
	int fail_count = 0;
	int checked_count = 0;
	int pushes_stored = 0, pushes_refused = 0;
	int pops_served = 0, pops_refused = 0;
	int scales_applied = 0, entries_scaled = 0, ignored_codes = 0;
	int holds_seen = 0;

	fifo_queue_with_affine_scale dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// random idling at about 8 percent, switched off in one long window
	function automatic bit take_break();
		if (cycle_count >= 1500 && cycle_count < 3500) begin
			return 1'b0;
		end
		return $urandom_range(0, 99) < 8;
	endfunction

	function automatic logic [fqas_pkg::IDX_W-1:0] ring_advance(
		input logic [fqas_pkg::IDX_W-1:0] idx);
		return (idx == fqas_pkg::IDX_W'(fqas_pkg::DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

	// applies one item to the shadow queue and returns the result it must produce
	function automatic queue_outcome_t queue_step_outcome(input queue_op_t op);
		queue_outcome_t             res;
		logic [fqas_pkg::IDX_W-1:0] idx;
		res.status = fqas_pkg::STATUS_DONE;
		res.pop_word = '0;
		case (op.action)
			fqas_pkg::ACT_PUSH: begin
				if (shadow_count >= fqas_pkg::DEPTH) begin
					res.status = fqas_pkg::STATUS_FULL;
					pushes_refused++;
				end else begin
					shadow_ring[shadow_tail] = op.push_word;
					shadow_tail = ring_advance(shadow_tail);
					shadow_count++;
					pushes_stored++;
				end
			end
			fqas_pkg::ACT_POP: begin
				if (shadow_count == 0) begin
					res.status = fqas_pkg::STATUS_EMPTY;
					pops_refused++;
				end else begin
					res.pop_word = shadow_ring[shadow_head];
					shadow_head = ring_advance(shadow_head);
					shadow_count--;
					pops_served++;
				end
			end
			fqas_pkg::ACT_SCALE: begin
				// walk head to tail, products wrap at the word width
				idx = shadow_head;
				for (int n = 0; n < shadow_count; n++) begin
					shadow_ring[idx] = shadow_ring[idx] * op.multiplier + op.addend;
					idx = ring_advance(idx);
				end
				if (shadow_count != 0) begin
					scales_applied++;
					entries_scaled += shadow_count;
				end
			end
			default: begin
				ignored_codes++;
			end
		endcase
		res.is_empty = (shadow_count == 0);
		return res;
	endfunction

	// sender: predicts at each accept, then loads the next item or idles
	always @(posedge clk or negedge arst_n) begin
		queue_outcome_t res;
		logic           load;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				res = queue_step_outcome(live_op);
				awaited_outcomes.push_back(res);
			end
			if (!s_tvalid || s_tready) begin
				load = 1'b0;
				// a hold marker stays until every awaited result has come back
				if (op_backlog.size() != 0 && op_backlog[0].hold &&
				    awaited_outcomes.size() == 0) begin
					void'(op_backlog.pop_front());
					holds_seen++;
				end
				if (op_backlog.size() != 0 && !op_backlog[0].hold && !take_break()) begin
					load = 1'b1;
					live_op = op_backlog.pop_front();
					s_tdata <= {live_op.addend, live_op.multiplier, live_op.push_word};
					s_tuser <= live_op.action;
				end
				s_tvalid <= load;
			end
		end
	end

	// receiver: checks each accepted result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		queue_outcome_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited_outcomes.size() == 0) begin
					$error("result with none awaited: status %0d pop_word %h is_empty %0d",
					       m_tuser[1:0], m_tdata, m_tuser[2]);
					fail_count++;
				end else begin
					want = awaited_outcomes.pop_front();
					checked_count++;
					if (m_tuser[1:0] !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, m_tuser[1:0]);
						fail_count++;
					end
					if (m_tdata !== want.pop_word) begin
						$error("pop_word: expected %h, actual %h", want.pop_word, m_tdata);
						fail_count++;
					end
					if (m_tuser[2] !== want.is_empty) begin
						$error("is_empty: expected %0d, actual %0d", want.is_empty, m_tuser[2]);
						fail_count++;
					end
				end
			end
			m_tready <= !take_break();
		end
	end

	task automatic queue_up(input logic [1:0] action,
	                        input logic [fqas_pkg::WORD_W-1:0] word,
	                        input logic [fqas_pkg::WORD_W-1:0] mul,
	                        input logic [fqas_pkg::WORD_W-1:0] add);
		queue_op_t op;
		op.action = action;
		op.push_word = word;
		op.multiplier = mul;
		op.addend = add;
		op.hold = 1'b0;
		op_backlog.push_back(op);
	endtask

	task automatic queue_hold();
		queue_op_t op;
		op.action = ACT_UNUSED;
		op.push_word = '0;
		op.multiplier = '0;
		op.addend = '0;
		op.hold = 1'b1;
		op_backlog.push_back(op);
	endtask

	// word values leaning toward the extremes
	function automatic logic [fqas_pkg::WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 32'd1;
			3: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int made;
		int mode;
		int push_pct;
		int pick;
		logic [1:0] act;

		// directed: empty corners, unused code, fill to full, scale extremes
		queue_up(fqas_pkg::ACT_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_up(fqas_pkg::ACT_SCALE, 32'h1234_5678, 32'd3, 32'd5);
		queue_up(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_up(fqas_pkg::ACT_PUSH, 32'h0000_0000, 32'h0, 32'h0);
		queue_up(fqas_pkg::ACT_PUSH, 32'hFFFF_FFFF, 32'h0, 32'h0);
		queue_up(fqas_pkg::ACT_PUSH, 32'h5555_5555, 32'h0, 32'h0);
		queue_up(fqas_pkg::ACT_PUSH, 32'hAAAA_AAAA, 32'h0, 32'h0);
		queue_up(fqas_pkg::ACT_PUSH, 32'h0000_0001, 32'h0, 32'h0);
		queue_up(fqas_pkg::ACT_PUSH, 32'h8000_0000, 32'h0, 32'h0);
		for (int k = 0; k < fqas_pkg::DEPTH - 6; k++) begin
			queue_up(fqas_pkg::ACT_PUSH, $urandom, $urandom, $urandom);
		end
		// push into a full ring, then scale every slot with wrapping arithmetic
		queue_up(fqas_pkg::ACT_PUSH, 32'hDEAD_BEEF, 32'h0, 32'h0);
		queue_up(fqas_pkg::ACT_SCALE, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_up(fqas_pkg::ACT_POP, 32'h0, 32'h0, 32'h0);
		queue_up(fqas_pkg::ACT_SCALE, 32'hFFFF_FFFF, 32'h0, 32'h0);
		queue_up(fqas_pkg::ACT_POP, 32'h0, 32'h0, 32'h0);
		queue_hold();
		made = 23;

		// random bursts that fill, drain or hover so both ends are reached often
		while (made < ITEM_TARGET) begin
			mode = $urandom_range(0, 2);
			push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
			repeat ($urandom_range(4, 40)) begin
				pick = $urandom_range(0, 99);
				if (pick < 2) begin
					act = ACT_UNUSED;
				end else if (pick < 12) begin
					act = fqas_pkg::ACT_SCALE;
				end else if ($urandom_range(0, 99) < push_pct) begin
					act = fqas_pkg::ACT_PUSH;
				end else begin
					act = fqas_pkg::ACT_POP;
				end
				queue_up(act, pick_word(), pick_word(), pick_word());
				if (act != ACT_UNUSED) begin
					made++;
				end
			end
			if ($urandom_range(0, 11) == 0) begin
				queue_hold();
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (op_backlog.size() != 0 || s_tvalid || awaited_outcomes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered: %0d pushes stored, %0d refused full, %0d pops served, %0d refused empty",
		         pushes_stored, pushes_refused, pops_served, pops_refused);
		$display("covered: %0d scales over %0d entries, %0d unused codes, %0d hold-offs, %0d checked",
		         scales_applied, entries_scaled, ignored_codes, holds_seen, checked_count);
		if (fail_count == 0) begin
			$display("fifo_queue_with_affine_scale_tb passed");
		end else begin
			$display("fifo_queue_with_affine_scale_tb failed");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("timeout with %0d results still awaited", awaited_outcomes.size());
		$display("fifo_queue_with_affine_scale_tb failed");
		$finish;
	end

endmodule

// ===== fifo_queue_with_affine_scale.f =====
sv/fqas_pkg.sv
sv/fqas_ram.sv
sv/fqas_mac.sv
sv/fifo_queue_with_affine_scale.sv
sv/fqas_checker.sv
dv/fifo_queue_with_affine_scale_tb.sv
